/* design/deadline_task_picker_top_defines.svh */
// Assertion macros shared by the deadline task picker.
// Depends on nothing; included by the top level only.
`ifndef DEADLINE_TASK_PICKER_TOP_DEFINES_SVH
`define DEADLINE_TASK_PICKER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DTP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define DTP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/dtp_pkg.sv */
// Shared constants, codes and types of the deadline task picker.
// Depends on nothing; imported by every module and interface.
`default_nettype none

package dtp_pkg;

   localparam int unsigned TABLE_DEPTH = 16;
   localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
   localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int unsigned TIME_W      = 63;
   localparam int unsigned KEY_W       = 64;
   localparam int unsigned HANDLE_W    = 16;

   // largest positive signed 64-bit key, start value of the running best
   localparam logic [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   typedef enum logic [1:0] {
      STAT_PUSHED = 2'd0,
      STAT_FULL   = 2'd1,
      STAT_POPPED = 2'd2,
      STAT_NONE   = 2'd3
   } status_type;

   typedef struct packed {
      logic                opcode;
      logic [HANDLE_W-1:0] task_handle;
      logic [TIME_W-1:0]   period;
      logic [TIME_W-1:0]   last_run_time;
      logic [TIME_W-1:0]   process_time;
      logic [TIME_W-1:0]   now_time;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]          status;
      logic [HANDLE_W-1:0] picked_handle;
   } rsp_payload_type;

   typedef struct packed {
      logic [HANDLE_W-1:0] handle;
      logic [TIME_W-1:0]   period;
      logic [TIME_W-1:0]   last_run;
      logic [TIME_W-1:0]   duration;
   } entry_type;

   typedef struct packed {
      logic                busy;
      logic                found;
      logic [IDX_W-1:0]    win_idx;
      logic [HANDLE_W-1:0] handle;
   } scan_result_type;

endpackage

`default_nettype wire

/* design/dtp_ifs.sv */
// Valid/ready channel interfaces for the request and response sides.
// Depends on dtp_pkg for the payload types.
`default_nettype none

interface dtp_req_if
   import dtp_pkg::*;
();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface dtp_rsp_if
   import dtp_pkg::*;
();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* design/dtp_table.sv */
// Task table memory: one write port and one registered read port.
// Depends on dtp_pkg for the entry type and depth.
`default_nettype none

module dtp_table
   import dtp_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [IDX_W-1:0] wr_addr,
   input  wire entry_type        wr_data,
   input  wire logic             rd_en,
   input  wire logic [IDX_W-1:0] rd_addr,
   output      entry_type        rd_data
);

   entry_type mem_ff [TABLE_DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* design/dtp_scan.sv */
// Minimum-search unit: one entry per cycle through subtract, subtract, compare.
// Depends on dtp_pkg for entry and result types.
`default_nettype none

module dtp_scan
   import dtp_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              clear,
   input  wire logic              in_valid,
   input  wire logic [IDX_W-1:0]  in_idx,
   input  wire entry_type         in_entry,
   input  wire logic [TIME_W-1:0] now_time,
   output      scan_result_type   result
);

   // stage 1: elapsed time
   logic                v1_ff, v1_in;
   logic [IDX_W-1:0]    idx1_ff;
   logic [HANDLE_W-1:0] handle1_ff;
   logic [TIME_W-1:0]   period1_ff;
   logic [TIME_W-1:0]   dur1_ff;
   logic [KEY_W-1:0]    elapsed1_ff, elapsed1_in;

   // stage 2: key
   logic                v2_ff, v2_in;
   logic [IDX_W-1:0]    idx2_ff;
   logic [HANDLE_W-1:0] handle2_ff;
   logic                periodic2_ff;
   logic [KEY_W-1:0]    key2_ff, key2_in;
   logic [TIME_W-1:0]   dur2_ff;

   // running best
   logic [KEY_W-1:0]    best_ff, best_in;
   logic                found_ff, found_in;
   logic [IDX_W-1:0]    win_ff, win_in;
   logic [HANDLE_W-1:0] whandle_ff, whandle_in;
   logic                qualify;

   assign v1_in       = in_valid;
   assign elapsed1_in = {1'b0, now_time} - {1'b0, in_entry.last_run};
   assign v2_in       = v1_ff;
   assign key2_in     = (period1_ff != '0) ? ({1'b0, period1_ff} - elapsed1_ff)
                                           : {1'b0, dur1_ff};

   assign qualify = v2_ff && ($signed(key2_ff) < $signed(best_ff)) &&
                    (!periodic2_ff || ($signed(key2_ff) < $signed({1'b0, dur2_ff})));

   always_comb begin
      best_in    = best_ff;
      found_in   = found_ff;
      win_in     = win_ff;
      whandle_in = whandle_ff;
      priority if (clear) begin
         best_in  = KEY_MAX;
         found_in = 1'b0;
      end else if (qualify) begin
         best_in    = key2_ff;
         found_in   = 1'b1;
         win_in     = idx2_ff;
         whandle_in = handle2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         found_ff <= 1'b0;
         best_ff  <= KEY_MAX;
      end else begin
         v1_ff    <= v1_in;
         v2_ff    <= v2_in;
         found_ff <= found_in;
         best_ff  <= best_in;
      end
   end

   always_ff @(posedge clock) begin
      idx1_ff      <= in_idx;
      handle1_ff   <= in_entry.handle;
      period1_ff   <= in_entry.period;
      dur1_ff      <= in_entry.duration;
      elapsed1_ff  <= elapsed1_in;
      idx2_ff      <= idx1_ff;
      handle2_ff   <= handle1_ff;
      periodic2_ff <= (period1_ff != '0);
      key2_ff      <= key2_in;
      dur2_ff      <= dur1_ff;
      win_ff       <= win_in;
      whandle_ff   <= whandle_in;
   end

   assign result.busy    = v1_ff | v2_ff;
   assign result.found   = found_ff;
   assign result.win_idx = win_ff;
   assign result.handle  = whandle_ff;

endmodule

`default_nettype wire

/* design/deadline_task_picker_top.sv */
// Deadline task picker top level: sequencer, entry count and response register.
// Depends on dtp_pkg, dtp_ifs, dtp_table, dtp_scan and the assertion macro header.
//
// Usage:
//   req_chan carries one command per transfer: push (append a task with its
//   handle, period, last run time and processing time) or pop (pick the task
//   with the smallest key at now_time, remove it by moving the last
//   entry into its slot). The key is the remaining time of a periodic task,
//   which is eligible only below its processing time, or the processing
//   time of an aperiodic task. rsp_chan returns exactly one status and
//   handle per command, in order. A push, or a pop on an empty table, goes
//   straight to the finish step. Any other pop does one table read per entry,
//   drains the read and compare pipeline and, if an entry qualified, moves
//   the last entry into the winner's slot (read, then write) before finishing.
//   The table's single read port sets the scan rate: one entry per cycle.
//   A new command is taken only while the sequencer is idle; one finished
//   response may wait in the output register while the next command runs.
//   A stalled receiver holds the response; the block then stalls in its
//   final step until the output register frees up.
//   Reset empties the table (entry count zero); the stored entries are not
//   cleared, as only entries below the count are ever read.
`default_nettype none
`include "deadline_task_picker_top_defines.svh"

module deadline_task_picker_top
   import dtp_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   dtp_req_if.sink    req_chan,
   dtp_rsp_if.source  rsp_chan
);

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_SCAN    = 6'b000010,
      ST_DRAIN   = 6'b000100,
      ST_MOVE_RD = 6'b001000,
      ST_MOVE_WR = 6'b010000,
      ST_FINISH  = 6'b100000
   } state_type;

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    scan_idx_ff, scan_idx_in;
   logic                rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0]    rd_idx_ff, rd_idx_in;
   status_type          status_ff, status_in;
   logic [TIME_W-1:0]   now_ff, now_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_payload_type     rsp_data_ff, rsp_data_in;

   logic                accept;
   logic                room;
   logic [CNT_W-1:0]    last_cnt;
   logic                tbl_wr_en;
   logic [IDX_W-1:0]    tbl_wr_addr;
   entry_type           tbl_wr_data;
   logic                tbl_rd_en;
   logic [IDX_W-1:0]    tbl_rd_addr;
   entry_type           tbl_rd_data;
   logic                scan_clear;
   scan_result_type     scan_res;
   logic                rsp_load;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign room           = (count_ff < CNT_W'(TABLE_DEPTH));
   assign last_cnt       = count_ff - CNT_W'(1);
   assign rsp_load       = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_chan.ready);

   dtp_table u_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr_data),
      .rd_en   (tbl_rd_en),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd_data)
   );

   dtp_scan u_scan (
      .clock    (clock),
      .reset    (reset),
      .clear    (scan_clear),
      .in_valid (rd_valid_ff),
      .in_idx   (rd_idx_ff),
      .in_entry (tbl_rd_data),
      .now_time (now_ff),
      .result   (scan_res)
   );

   // Sequencer: push writes at the tail if there is room; pop scans, drains,
   // then moves the last entry into the winner's slot if one was found.
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      scan_idx_in = scan_idx_ff;
      rd_valid_in = 1'b0;
      rd_idx_in   = rd_idx_ff;
      status_in   = status_ff;
      now_in      = now_ff;
      scan_clear  = 1'b0;
      tbl_wr_en   = 1'b0;
      tbl_wr_addr = count_ff[IDX_W-1:0];
      tbl_wr_data.handle   = req_chan.payload.task_handle;
      tbl_wr_data.period   = req_chan.payload.period;
      tbl_wr_data.last_run = req_chan.payload.last_run_time;
      tbl_wr_data.duration = req_chan.payload.process_time;
      tbl_rd_en   = 1'b0;
      tbl_rd_addr = scan_idx_ff[IDX_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_chan.payload.opcode == OP_PUSH) begin
                  state_in = ST_FINISH;
                  if (room) begin
                     tbl_wr_en = 1'b1;
                     count_in  = count_ff + CNT_W'(1);
                     status_in = STAT_PUSHED;
                  end else begin
                     status_in = STAT_FULL;
                  end
               end else begin
                  now_in      = req_chan.payload.now_time;
                  scan_clear  = 1'b1;
                  scan_idx_in = '0;
                  if (count_ff == '0) begin
                     status_in = STAT_NONE;
                     state_in  = ST_FINISH;
                  end else begin
                     state_in = ST_SCAN;
                  end
               end
            end
         end
         ST_SCAN: begin
            // issue one table read per cycle; tag it with its index
            tbl_rd_en   = 1'b1;
            rd_valid_in = 1'b1;
            rd_idx_in   = scan_idx_ff[IDX_W-1:0];
            scan_idx_in = scan_idx_ff + CNT_W'(1);
            if (scan_idx_ff == last_cnt) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // hold until the last read has left the compare pipeline
            if (!rd_valid_ff && !scan_res.busy) begin
               if (scan_res.found) begin
                  state_in = ST_MOVE_RD;
               end else begin
                  status_in = STAT_NONE;
                  state_in  = ST_FINISH;
               end
            end
         end
         ST_MOVE_RD: begin
            tbl_rd_en   = 1'b1;
            tbl_rd_addr = last_cnt[IDX_W-1:0];
            state_in    = ST_MOVE_WR;
         end
         ST_MOVE_WR: begin
            tbl_wr_en   = 1'b1;
            tbl_wr_addr = scan_res.win_idx;
            tbl_wr_data = tbl_rd_data;
            count_in    = last_cnt;
            status_in   = STAT_POPPED;
            state_in    = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Response register: load on finish, drop after the transfer.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in         = 1'b1;
         rsp_data_in.status   = status_ff;
         rsp_data_in.picked_handle = (status_ff == STAT_POPPED) ? scan_res.handle : '0;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff <= scan_idx_in;
      rd_idx_ff   <= rd_idx_in;
      status_ff   <= status_in;
      now_ff      <= now_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   // Checks on the sequencer and entry count.
   `DTP_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(TABLE_DEPTH), "entry count above table depth")
   `DTP_ASSERT_NEXT(a_push_grows, clock, reset, accept && (req_chan.payload.opcode == OP_PUSH) && room, count_ff == ($past(count_ff) + CNT_W'(1)), "push with room did not add an entry")
   `DTP_ASSERT_NEXT(a_shrink_on_move, clock, reset, state_ff != ST_MOVE_WR, count_ff >= $past(count_ff), "entry count dropped outside the removal step")

endmodule

`default_nettype wire

/* test/deadline_task_picker_top_tb.sv */
// Self-checking testbench for deadline_task_picker_top: push/pop commands with
// random idling on both channels, checked against an in-bench task table model.
// Depends on dtp_pkg, dtp_ifs and the deadline_task_picker_top RTL.
`timescale 1ns / 1ps

module deadline_task_picker_top_tb;
   import dtp_pkg::*;

   localparam int unsigned RANDOM_ITEMS = 1830;
   localparam int unsigned PHASE_ITEMS  = 40;    // items per push/pop mix phase
   localparam int unsigned HOLD_AT_ITEM = 700;   // random item that starts the long hold-off
   localparam int unsigned HOLD_CYCLES  = 400;
   localparam int unsigned DRAIN_CYCLES = 30;    // above the worst pop latency
   localparam int unsigned IDLE_LIMIT   = 4000;  // cycles with no transfer on either side

   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

   typedef enum int unsigned {
      RX_STEADY,
      RX_COIN,
      RX_EVERY_FOURTH,
      RX_RARE_STALL
   } rx_mode_type;

   // Task table model: mirrors the entries and turns each accepted command
   // into the status/handle the block must return.
   class task_pick_scoreboard;
      logic [HANDLE_W-1:0] handles   [TABLE_DEPTH];
      logic [KEY_W-1:0]    periods   [TABLE_DEPTH];
      logic [KEY_W-1:0]    last_runs [TABLE_DEPTH];
      logic [KEY_W-1:0]    durations [TABLE_DEPTH];
      int unsigned         entry_total;
      rsp_payload_type     expected_status_q[$];
      int unsigned         mismatches;
      int unsigned         checked;
      int unsigned         n_pushed, n_full, n_picked, n_none;

      function new();
         entry_total = 0;
         mismatches  = 0;
         checked     = 0;
         n_pushed    = 0;
         n_full      = 0;
         n_picked    = 0;
         n_none      = 0;
      endfunction

      function int unsigned pending();
         return expected_status_q.size();
      endfunction

      function void note_command(req_payload_type cmd);
         rsp_payload_type  exp;
         logic [KEY_W-1:0] best, remaining, now_key;
         logic             found;
         int unsigned      win, last, i;
         exp.picked_handle = '0;
         if (cmd.opcode == OP_PUSH) begin
            if (entry_total >= TABLE_DEPTH) begin
               exp.status = STAT_FULL;
               n_full++;
            end else begin
               handles[entry_total]   = cmd.task_handle;
               periods[entry_total]   = {1'b0, cmd.period};
               last_runs[entry_total] = {1'b0, cmd.last_run_time};
               durations[entry_total] = {1'b0, cmd.process_time};
               entry_total++;
               exp.status = STAT_PUSHED;
               n_pushed++;
            end
         end else begin
            // scan in index order; strict less-than keeps the first minimum
            best    = KEY_MAX;
            found   = 1'b0;
            win     = 0;
            now_key = {1'b0, cmd.now_time};
            for (i = 0; i < entry_total; i++) begin
               if (periods[i] != '0) begin
                  remaining = periods[i] - (now_key - last_runs[i]);
                  if ($signed(remaining) < $signed(best) &&
                      $signed(remaining) < $signed(durations[i])) begin
                     best  = remaining;
                     win   = i;
                     found = 1'b1;
                  end
               end else if ($signed(durations[i]) < $signed(best)) begin
                  best  = durations[i];
                  win   = i;
                  found = 1'b1;
               end
            end
            if (found) begin
               // swap-remove: move the last entry into the winner's slot
               last              = entry_total - 1;
               exp.picked_handle = handles[win];
               handles[win]      = handles[last];
               periods[win]      = periods[last];
               last_runs[win]    = last_runs[last];
               durations[win]    = durations[last];
               entry_total       = last;
               exp.status        = STAT_POPPED;
               n_picked++;
            end else begin
               exp.status = STAT_NONE;
               n_none++;
            end
         end
         expected_status_q.push_back(exp);
      endfunction

      function void check_status(rsp_payload_type got);
         rsp_payload_type exp;
         checked++;
         if (expected_status_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("[%0t] unexpected response: status %0d handle %h",
                        $realtime, got.status, got.picked_handle);
            return;
         end
         exp = expected_status_q.pop_front();
         if (got.status !== exp.status || got.picked_handle !== exp.picked_handle) begin
            mismatches++;
            if (mismatches <= 10)
               $display("[%0t] mismatch: expected status %0d handle %h, got status %0d handle %h",
                        $realtime, exp.status, exp.picked_handle, got.status,
                        got.picked_handle);
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   dtp_req_if req_bus ();
   dtp_rsp_if rsp_bus ();

   deadline_task_picker_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   task_pick_scoreboard board;
   logic [TIME_W-1:0]   tick_now;      // running "current time" for well-formed traffic
   bit                  hold_request;  // ask the receiver for one long hold-off
   int unsigned         idle_cycles;

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Random 63-bit value biased toward the extremes, for fields and noise.
   function automatic logic [TIME_W-1:0] wide_time();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return TIME_MAX;
         2:       return TIME_W'($urandom_range(0, 15));
         3:       return TIME_MAX - TIME_W'($urandom_range(0, 15));
         default: return raw[TIME_W-1:0];
      endcase
   endfunction

   // Build a push; the ignored now_time field carries noise.
   function automatic req_payload_type make_push(input logic [HANDLE_W-1:0] handle,
                                                 input logic [TIME_W-1:0]   period,
                                                 input logic [TIME_W-1:0]   last_run,
                                                 input logic [TIME_W-1:0]   duration);
      req_payload_type cmd;
      cmd.opcode        = OP_PUSH;
      cmd.task_handle   = handle;
      cmd.period        = period;
      cmd.last_run_time = last_run;
      cmd.process_time  = duration;
      cmd.now_time      = wide_time();
      return cmd;
   endfunction

   // Build a pop; every field the pop ignores carries noise.
   function automatic req_payload_type make_pop(input logic [TIME_W-1:0] now_time);
      req_payload_type cmd;
      cmd.opcode        = OP_POP;
      cmd.task_handle   = HANDLE_W'($urandom_range(0, 65535));
      cmd.period        = wide_time();
      cmd.last_run_time = wide_time();
      cmd.process_time  = wide_time();
      cmd.now_time      = now_time;
      return cmd;
   endfunction

   // Mostly well-formed commands around tick_now, so remaining times land near
   // the processing times and the pick really depends on the comparison.
   function automatic req_payload_type random_command(input int unsigned pop_pct);
      logic              noisy;
      logic [TIME_W-1:0] period, last_run;
      noisy = ($urandom_range(0, 5) == 0);
      if ($urandom_range(1, 100) <= pop_pct) begin
         if (noisy)
            return make_pop(wide_time());
         tick_now = tick_now + TIME_W'($urandom_range(0, 40));
         return make_pop(tick_now);
      end
      if (noisy)
         return make_push(HANDLE_W'($urandom_range(0, 65535)),
                          ($urandom_range(0, 3) == 0) ? '0 : wide_time(),
                          wide_time(), wide_time());
      period   = ($urandom_range(0, 3) == 0) ? '0 : TIME_W'($urandom_range(1, 600));
      last_run = tick_now - TIME_W'($urandom_range(0, 600));
      return make_push(HANDLE_W'($urandom_range(0, 65535)), period, last_run,
                       TIME_W'($urandom_range(0, 600)));
   endfunction

   // Offer one command and hold it until the transfer, then record it.
   task automatic send_command(input req_payload_type cmd);
      @(negedge clock);
      req_bus.valid   <= 1'b1;
      req_bus.payload <= cmd;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      board.note_command(cmd);
   endtask

   // Drop valid for a gap; scramble the payload so nothing leans on it.
   task automatic pause_sender(input int unsigned cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_bus.valid   <= 1'b0;
         req_bus.payload <= make_pop(wide_time());
      end
   endtask

   // Sender: reset, directed commands, random bursts, then drain and report.
   initial begin
      int unsigned item, burst_left, pop_pct, i;
      board           = new();
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.payload = '0;
      hold_request    = 1'b0;
      tick_now        = TIME_W'(1000);
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // pop on an empty table
      send_command(make_pop('0));
      // fill the table with extremes: aperiodic at max duration, periodic at
      // max period, a remaining time that wraps past the sign, one that
      // never qualifies, and two aperiodic ties where the first must win
      send_command(make_push(16'h0000, '0, TIME_MAX, TIME_MAX));
      send_command(make_push(16'hFFFF, TIME_MAX, '0, TIME_MAX));
      send_command(make_push(16'h0001, TIME_W'(1), TIME_MAX, TIME_W'(10)));
      send_command(make_push(16'h0002, TIME_W'(100), '0, TIME_W'(10)));
      send_command(make_push(16'h00A1, '0, '0, TIME_W'(7)));
      send_command(make_push(16'h00A2, '0, '0, TIME_W'(7)));
      for (i = 0; i < TABLE_DEPTH - 6; i++)
         send_command(make_push(HANDLE_W'(32'h0100 + i), TIME_W'(1000 + i), '0,
                                TIME_W'(2000)));
      // push on a full table
      send_command(make_push(16'h0BAD, TIME_W'(5), TIME_W'(5), TIME_W'(5)));
      // pops at times that move the winner around
      send_command(make_pop('0));
      send_command(make_pop('0));
      send_command(make_pop('0));
      send_command(make_pop(TIME_MAX));
      send_command(make_pop(TIME_W'(95)));
      send_command(make_pop(TIME_W'(50)));
      send_command(make_pop('0));

      // random part: phases lean toward pushes (fill up to full) or pops (drain)
      burst_left = $urandom_range(1, 30);
      pop_pct    = 50;
      for (item = 0; item < RANDOM_ITEMS; item++) begin
         if (item % PHASE_ITEMS == 0) begin
            case ($urandom_range(0, 2))
               0:       pop_pct = 25;
               1:       pop_pct = 50;
               default: pop_pct = 75;
            endcase
         end
         // keep offering while the receiver holds off, so the block backs up
         if (item == HOLD_AT_ITEM)
            hold_request = 1'b1;
         send_command(random_command(pop_pct));
         if (burst_left == 0) begin
            pause_sender($urandom_range(1, 12));
            burst_left = $urandom_range(1, 30);
         end else begin
            burst_left--;
         end
      end
      @(negedge clock);
      req_bus.valid <= 1'b0;

      // wait for every expected response, then let the block settle
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d pushes, %0d on a full table, %0d picks, %0d empty-handed pops.",
               board.n_pushed, board.n_full, board.n_picked, board.n_none);
      $display("Checked %0d responses, %0d mismatches.", board.checked, board.mismatches);
      if (board.mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Receiver: stall in changing patterns; once, hold off for a long stretch.
   initial begin
      rx_mode_type mode;
      int unsigned mode_left, phase, hold_left;
      rsp_bus.ready = 1'b0;
      mode          = RX_STEADY;
      mode_left     = 0;
      phase         = 0;
      hold_left     = 0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_request && hold_left == 0) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode      = rx_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            phase++;
            case (mode)
               RX_STEADY:       rsp_bus.ready <= 1'b1;
               RX_COIN:         rsp_bus.ready <= ($urandom_range(0, 1) == 1);
               RX_EVERY_FOURTH: rsp_bus.ready <= (phase % 4 == 0);
               default:         rsp_bus.ready <= ($urandom_range(0, 9) != 0);
            endcase
         end
      end
   end

   // Check each response transfer against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
         board.check_status(rsp_bus.payload);
   end

   // Watchdog: end the run if no transfer happens on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Timeout: no transfer for %0d cycles, %0d responses outstanding.",
                  idle_cycles, board.pending());
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

/* deadline_task_picker_top.f */
+incdir+design
design/dtp_pkg.sv
design/dtp_ifs.sv
design/dtp_table.sv
design/dtp_scan.sv
design/deadline_task_picker_top.sv
test/deadline_task_picker_top_tb.sv
